FILE: hw/rtl/mfb_pkg.sv
package mfb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int FIRST_CODE        = 32;
    localparam int LAST_CODE         = 126;
    localparam int CELL_ADVANCE      = 5 + 1;
    localparam int GLYPH_COUNT       = 95;

    localparam logic [2:0] FUNC_CLEAR_ALL  = 3'd0;
    localparam logic [2:0] FUNC_CLEAR_RECT = 3'd1;
    localparam logic [2:0] FUNC_INV_RECT   = 3'd2;
    localparam logic [2:0] FUNC_SET_CURSOR = 3'd3;
    localparam logic [2:0] FUNC_DRAW_CHAR  = 3'd4;
    localparam logic [2:0] FUNC_READ_BYTE  = 3'd5;
    localparam logic [2:0] FUNC_PAGE_SENT  = 3'd6;

    localparam logic [0:0] REG_GLYPH_SCALE = 1'd0;

    // Each entry holds font columns 0..4 from the most significant byte down;
    // bit n of a column byte is font row n.
    localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

endpackage

FILE: hw/rtl/mono_framebuffer_text_blitter_core.sv
// Monochrome page-organized framebuffer with a 5x7 text blitter. Pixels live
// in one synchronous byte memory, one byte per (page, column), bit n holding
// row page*8+n. Every command gives exactly one result item carrying the dirty
// page mask, the next dirty page and the cursor. Clear rect and invert rect
// walk every touched column byte; draw char walks 5*scale columns by 5 page
// slots and skips the slots that lie off screen. Each touched byte is read
// through the single read port of the pixel memory and then written back
// modified. Clear all, and reset, run a clearing pass of one byte a cycle over
// the whole memory (1024 bytes at the default 128x64 size) while no item is
// taken; configuration writes are taken at any time. glyph_scale is written
// over the APB port at address 0.
module mono_framebuffer_text_blitter_core #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  rect_width,
    input  logic [7:0]  rect_height,
    input  logic [7:0]  char_code,
    input  logic [2:0]  page_index,
    input  logic [6:0]  column_index,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [7:0]  dirty_mask,
    output logic [3:0]  next_dirty,
    output logic [7:0]  cursor_col,
    output logic [7:0]  cursor_row
);

    localparam int PAGES_MEM  = (SCREEN_HEIGHT + 7) / 8;
    localparam int PAGE_CNT   = SCREEN_HEIGHT / 8;
    localparam int DEPTH      = PAGES_MEM * SCREEN_WIDTH;
    localparam int AW         = $clog2(DEPTH);
    localparam logic [8:0] W9 = 9'(SCREEN_WIDTH);
    localparam logic [8:0] H9 = 9'(SCREEN_HEIGHT);
    localparam logic [3:0] PM4 = 4'(PAGES_MEM);
    localparam logic [7:0] CLEAR_MASK = 8'((1 << PAGE_CNT) - 1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_RD, S_WR, S_RB, S_FIN
    } state_t;

    typedef enum logic [1:0] {
        OP_CLEAR, OP_INVERT, OP_GLYPH
    } op_t;

    state_t       state_reg;
    op_t          op_reg;
    logic [AW-1:0] addr_reg;
    logic         clr_report_reg;
    logic [3:0]   page_reg, page_lo_reg, page_hi_reg;
    logic [8:0]   col_reg, col_hi_reg;
    logic [8:0]   row_lo_reg, row_hi_reg;
    logic [2:0]   fcol_reg;
    logic [1:0]   dx_reg;
    logic [2:0]   scale_reg;
    logic [7:0]   code_reg;
    logic [2:0]   scale_cfg_reg;
    logic [7:0]   dirty_reg;
    logic [7:0]   cur_col_reg, cur_row_reg;
    logic [3:0]   from_reg;
    logic         is_read_reg;

    logic         out_valid_reg;
    logic [7:0]   read_data_reg, dirty_mask_reg, cursor_col_reg, cursor_row_reg;
    logic [3:0]   next_dirty_reg;

    logic [7:0]   mem [DEPTH];
    logic [7:0]   mem_rdata_reg;
    logic         mem_we;
    logic [AW-1:0] mem_waddr, pix_addr;
    logic [7:0]   mem_wdata, mod_byte;

    // pages that hold a row of lo..hi
    function automatic logic [7:0] page_span(logic [8:0] lo, logic [8:0] hi);
        logic [7:0] m;
        m = '0;
        for (int p = 0; p < 8; p++) begin
            m[p] = ({1'b0, 3'(p), 5'b0} >> 2 <= hi) && (({1'b0, 3'(p), 5'b0} >> 2)
                   + 9'd7 >= lo);
        end
        return m;
    endfunction

    // stretch a font column vertically by the scale
    function automatic logic [27:0] expand(logic [6:0] g, logic [2:0] s);
        logic [27:0] v;
        v = '0;
        for (int i = 0; i < 7; i++) begin
            case (s)
                3'd2: begin
                    v[i*2] = g[i]; v[i*2+1] = g[i];
                end
                3'd3: begin
                    v[i*3] = g[i]; v[i*3+1] = g[i]; v[i*3+2] = g[i];
                end
                3'd4: begin
                    v[i*4] = g[i]; v[i*4+1] = g[i];
                    v[i*4+2] = g[i]; v[i*4+3] = g[i];
                end
                default: v[i] = g[i];
            endcase
        end
        return v;
    endfunction

    // ---------------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = {29'd0, scale_cfg_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scale_cfg_reg <= 3'd1;
        end
        else if (psel && penable && pwrite && paddr[2] == mfb_pkg::REG_GLYPH_SCALE) begin
            scale_cfg_reg <= pwdata[2:0];
        end
    end

    // ---------------------------------------------------------------------
    // decode of the accepted command
    // ---------------------------------------------------------------------
    logic       accept;
    logic [2:0] eff_scale;
    logic [8:0] rect_yl, rect_xe, y_sum, x_sum, box_hi, glyph_col_hi;
    logic       rect_on, code_ok;
    logic [4:0] box_rows;

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    always_comb begin
        eff_scale = scale_cfg_reg;
        if (scale_cfg_reg == 3'd0) eff_scale = 3'd1;
        if (scale_cfg_reg > 3'd4) eff_scale = 3'd4;
        case (eff_scale)
            3'd2:    box_rows = 5'd16;
            3'd3:    box_rows = 5'd21;
            3'd4:    box_rows = 5'd28;
            default: box_rows = 5'd8;
        endcase
        y_sum   = {1'b0, pos_y} + {1'b0, rect_height} - 9'd1;
        rect_yl = (y_sum > H9 - 9'd1) ? H9 - 9'd1 : y_sum;
        x_sum   = {1'b0, pos_x} + {1'b0, rect_width};
        rect_xe = (x_sum > W9) ? W9 : x_sum;
        rect_on = ({1'b0, pos_x} < W9) && ({1'b0, pos_y} < H9) && (rect_height != 8'd0);
        code_ok = (char_code >= 8'(mfb_pkg::FIRST_CODE))
               && (char_code <= 8'(mfb_pkg::LAST_CODE));
        box_hi  = {1'b0, cur_row_reg} + {4'd0, box_rows} - 9'd1;
        if (box_hi > H9 - 9'd1) box_hi = H9 - 9'd1;
        glyph_col_hi = {1'b0, cur_col_reg} + 9'(5 * eff_scale) - 9'd1;
    end

    // ---------------------------------------------------------------------
    // byte walk: active slot, modify, memory hookup
    // ---------------------------------------------------------------------
    logic        active, step, col_last, page_last;
    logic [39:0] glyph_bits;
    logic [7:0]  glyph_col;
    logic [34:0] glyph_shift;
    logic [39:0] glyph_pad;
    logic [2:0]  slot;
    logic [7:0]  rect_mask, row_ok;
    logic [8:0]  row_n;

    always_comb begin
        active    = (col_reg < W9) && (page_reg < PM4);
        col_last  = (col_reg == col_hi_reg);
        page_last = (page_reg == page_hi_reg);
        step      = ((state_reg == S_RD) && !active) || (state_reg == S_WR);
        pix_addr  = AW'(int'(page_reg) * SCREEN_WIDTH + int'(col_reg));

        glyph_bits  = mfb_pkg::GLYPH_ROM[7'(code_reg - 8'(mfb_pkg::FIRST_CODE))];
        glyph_col   = glyph_bits[(3'd4 - fcol_reg) * 8 +: 8];
        glyph_shift = {7'd0, expand(glyph_col[6:0], scale_reg)} << cur_row_reg[2:0];
        glyph_pad   = {5'd0, glyph_shift};
        slot        = 3'(page_reg - page_lo_reg);

        for (int n = 0; n < 8; n++) begin
            row_n        = {page_reg, 5'd0} >> 2 | 9'(n);
            row_ok[n]    = row_n < H9;
            rect_mask[n] = (row_n >= row_lo_reg) && (row_n <= row_hi_reg);
        end

        case (op_reg)
            OP_CLEAR:  mod_byte = mem_rdata_reg & ~rect_mask;
            OP_INVERT: mod_byte = mem_rdata_reg ^ rect_mask;
            default:   mod_byte = mem_rdata_reg | (glyph_pad[slot * 8 +: 8] & row_ok);
        endcase

        mem_we    = (state_reg == S_CLR) || (state_reg == S_WR);
        mem_waddr = (state_reg == S_CLR) ? addr_reg : pix_addr;
        mem_wdata = (state_reg == S_CLR) ? 8'd0 : mod_byte;
    end

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[pix_addr];
    end

    // ---------------------------------------------------------------------
    // next dirty page search on the final mask
    // ---------------------------------------------------------------------
    logic [3:0] nd;
    logic       nd_found;

    always_comb begin
        nd       = 4'd8;
        nd_found = 1'b0;
        for (int p = 0; p < 8; p++) begin
            if (!nd_found && 4'(p) >= from_reg && dirty_reg[p]) begin
                nd       = 4'(p);
                nd_found = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_CLR;
            addr_reg       <= '0;
            clr_report_reg <= 1'b0;
            dirty_reg      <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            from_reg       <= '0;
            is_read_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            op_reg         <= OP_CLEAR;
        end
        else begin
            if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLR: begin
                    // sweep zeros one byte a cycle
                    addr_reg <= addr_reg + AW'(1);
                    if (addr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= clr_report_reg ? S_FIN : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        from_reg    <= '0;
                        is_read_reg <= 1'b0;
                        state_reg   <= S_FIN;
                        case (func)
                            mfb_pkg::FUNC_CLEAR_ALL: begin
                                dirty_reg      <= CLEAR_MASK;
                                cur_col_reg    <= '0;
                                cur_row_reg    <= '0;
                                addr_reg       <= '0;
                                clr_report_reg <= 1'b1;
                                state_reg      <= S_CLR;
                            end
                            mfb_pkg::FUNC_CLEAR_RECT, mfb_pkg::FUNC_INV_RECT: begin
                                op_reg <= (func == mfb_pkg::FUNC_INV_RECT) ? OP_INVERT
                                                                           : OP_CLEAR;
                                if (rect_on) begin
                                    dirty_reg   <= dirty_reg | page_span({1'b0, pos_y}, rect_yl);
                                    page_reg    <= {1'b0, pos_y[5:3]};
                                    page_lo_reg <= {1'b0, pos_y[5:3]};
                                    page_hi_reg <= {1'b0, rect_yl[5:3]};
                                    col_reg     <= {1'b0, pos_x};
                                    col_hi_reg  <= rect_xe - 9'd1;
                                    row_lo_reg  <= {1'b0, pos_y};
                                    row_hi_reg  <= rect_yl;
                                    if (rect_xe > {1'b0, pos_x}) begin
                                        state_reg <= S_RD;
                                    end
                                end
                            end
                            mfb_pkg::FUNC_SET_CURSOR: begin
                                cur_col_reg <= pos_x;
                                cur_row_reg <= pos_y;
                            end
                            mfb_pkg::FUNC_DRAW_CHAR: begin
                                op_reg    <= OP_GLYPH;
                                code_reg  <= char_code;
                                scale_reg <= eff_scale;
                                if (code_ok) begin
                                    cur_col_reg <= cur_col_reg
                                                 + 8'(mfb_pkg::CELL_ADVANCE * eff_scale);
                                    if ({1'b0, cur_row_reg} < H9) begin
                                        dirty_reg   <= dirty_reg
                                                     | page_span({1'b0, cur_row_reg}, box_hi);
                                        page_reg    <= {1'b0, cur_row_reg[5:3]};
                                        page_lo_reg <= {1'b0, cur_row_reg[5:3]};
                                        page_hi_reg <= {1'b0, cur_row_reg[5:3]} + 4'd4;
                                        col_reg     <= {1'b0, cur_col_reg};
                                        col_hi_reg  <= glyph_col_hi;
                                        fcol_reg    <= '0;
                                        dx_reg      <= '0;
                                        state_reg   <= S_RD;
                                    end
                                end
                            end
                            mfb_pkg::FUNC_READ_BYTE: begin
                                page_reg <= {1'b0, page_index};
                                col_reg  <= {2'b0, column_index};
                                if ({1'b0, page_index} < 4'(PAGE_CNT)
                                    && {2'b0, column_index} < W9) begin
                                    is_read_reg <= 1'b1;
                                    state_reg   <= S_RB;
                                end
                            end
                            mfb_pkg::FUNC_PAGE_SENT: begin
                                dirty_reg <= dirty_reg & ~(8'd1 << page_index);
                                from_reg  <= {1'b0, page_index} + 4'd1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    if (active) begin
                        state_reg <= S_WR;
                    end
                end
                S_WR: ;
                S_RB: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    clr_report_reg <= 1'b0;
                    out_valid_reg  <= 1'b1;
                    read_data_reg  <= is_read_reg ? mem_rdata_reg : 8'd0;
                    dirty_mask_reg <= dirty_reg;
                    next_dirty_reg <= nd;
                    cursor_col_reg <= cur_col_reg;
                    cursor_row_reg <= cur_row_reg;
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase

            // advance the walk: pages inside, columns outside
            if (step) begin
                state_reg <= S_RD;
                if (page_last) begin
                    page_reg <= page_lo_reg;
                    if (col_last) begin
                        state_reg <= S_FIN;
                    end
                    else begin
                        col_reg <= col_reg + 9'd1;
                        if ({1'b0, dx_reg} == scale_reg - 3'd1) begin
                            dx_reg   <= '0;
                            fcol_reg <= fcol_reg + 3'd1;
                        end
                        else begin
                            dx_reg <= dx_reg + 2'd1;
                        end
                    end
                end
                else begin
                    page_reg <= page_reg + 4'd1;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign dirty_mask = dirty_mask_reg;
    assign next_dirty = next_dirty_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_row = cursor_row_reg;

endmodule
